// ===== design/rsa_me_pkg.sv =====
// Shared types and constants for the RSA modular exponentiation unit.
// No dependencies; imported by rsa_me_mulmod and rsa_modular_exponentiation_unit.
`default_nettype none

package rsa_me_pkg;

  // Default key width of the datapath
  localparam int unsigned KEY_WIDTH_DEF = 32;

  // Fixed widths of the stream and configuration payloads
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS     = 2'd0,
    REG_PUBLIC_EXP  = 2'd1,
    REG_PRIVATE_EXP = 2'd2
  } cfg_reg_e;

  // Status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_status_t;

endpackage : rsa_me_pkg

`default_nettype wire

// ===== design/rsa_me_mulmod.sv =====
// Iterative shift-and-add modular multiplier: one multiplier bit per cycle.
// Depends on rsa_me_pkg.
`default_nettype none

module rsa_me_mulmod
  import rsa_me_pkg::*;
#(
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [KEY_WIDTH-1:0] a_i,
  input  logic [KEY_WIDTH-1:0] b_i,
  input  logic [KEY_WIDTH-1:0] mod_i,
  output mm_status_t           status_o,
  output logic [KEY_WIDTH-1:0] product_o
);

  localparam int unsigned CNT_W = $clog2(KEY_WIDTH);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [KEY_WIDTH-1:0] a_q, b_q, acc_q;
  logic [KEY_WIDTH:0]   dbl, dbl_red, sum, sum_red;
  logic [KEY_WIDTH:0]   mod_ext;
  logic [KEY_WIDTH-1:0] addend;

  // acc stays below the modulus: double, reduce, add a or 0, reduce
  always_comb begin
    mod_ext = {1'b0, mod_i};
    dbl     = {acc_q, 1'b0};
    dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
    addend  = b_q[KEY_WIDTH-1] ? a_q : '0;
    sum     = dbl_red + {1'b0, addend};
    sum_red = (sum >= mod_ext) ? sum - mod_ext : sum;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(KEY_WIDTH - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= {b_q[KEY_WIDTH-2:0], 1'b0};
      acc_q <= sum_red[KEY_WIDTH-1:0];
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign product_o     = acc_q;

endmodule : rsa_me_mulmod

`default_nettype wire

// ===== design/rsa_modular_exponentiation_unit.sv =====
// RSA modular exponentiation unit: config registers, square-and-multiply
// sequencer and output register. Depends on rsa_me_pkg and rsa_me_mulmod.
//
// Usage:
//  - Configuration channel (cfg_valid_i/cfg_ready_o, cfg_addr_i, cfg_data_i)
//    writes modulus (index 0), public exponent (1) and private exponent (2);
//    other indexes are dropped. Write only while the unit is idle.
//  - Input stream: s_axis_tdata_i is the value, s_axis_tuser_i the mode
//    (0: public exponent, error if value > modulus; 1: private exponent).
//  - Output stream: m_axis_tdata_o is the result, m_axis_tuser_o the error
//    flag (result is 0 with it).
//  - Every product goes through one shared shift-and-add modular multiplier.
//    An item costs one reduction of the value plus one squaring per exponent
//    bit and one multiply per set bit. Error items and a zero modulus skip
//    the multiplier and go from the finish state to the output register.
//  - One item is worked on at a time; s_axis_tready_o is high only when idle.
//  - A finished item waits in the output register; the unit takes a new item
//    meanwhile and holds its next result until the receiver takes the first.
//  - Reset: modulus=2, exponents=1, no item pending.
`default_nettype none

module rsa_modular_exponentiation_unit
  import rsa_me_pkg::*;
#(
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  // input items
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [DATA_W-1:0]    s_axis_tdata_i,   // [31:0] value
  input  logic                 s_axis_tuser_i,   // [0] mode
  // result items
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [DATA_W-1:0]    m_axis_tdata_o,   // [31:0] result
  output logic                 m_axis_tuser_o    // [0] error
);

  localparam int unsigned CNT_W = $clog2(KEY_WIDTH);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_SQUARE = 5'b00100,
    ST_MULT   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [KEY_WIDTH-1:0] modulus_q, pub_exp_q, priv_exp_q;
  logic [KEY_WIDTH-1:0] cfg_data_ext;
  logic [KEY_WIDTH-1:0] exp_q, exp_d;
  logic [KEY_WIDTH-1:0] base_q, base_d;
  logic [KEY_WIDTH-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]     bit_q, bit_d;
  logic                 err_q, err_d;
  logic                 out_valid_q, out_valid_d;
  logic [DATA_W-1:0]    out_data_q;
  logic                 out_err_q;
  logic                 out_load;

  logic [KEY_WIDTH-1:0] value_ext, one_mod;
  logic                 in_accept;

  logic                 mm_start;
  logic [KEY_WIDTH-1:0] mm_a, mm_b, mm_product;
  mm_status_t           mm_status;

  // configuration registers, always ready
  assign cfg_ready_o  = 1'b1;
  assign cfg_data_ext = KEY_WIDTH'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q  <= KEY_WIDTH'(2);
      pub_exp_q  <= KEY_WIDTH'(1);
      priv_exp_q <= KEY_WIDTH'(1);
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_MODULUS:     modulus_q  <= cfg_data_ext;
        REG_PUBLIC_EXP:  pub_exp_q  <= cfg_data_ext;
        REG_PRIVATE_EXP: priv_exp_q <= cfg_data_ext;
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign value_ext       = KEY_WIDTH'(s_axis_tdata_i);
  // 1 mod n: zero for a modulus of one
  assign one_mod         = (modulus_q == KEY_WIDTH'(1)) ? '0 : KEY_WIDTH'(1);

  // shared modular multiplier
  rsa_me_mulmod #(
    .KEY_WIDTH(KEY_WIDTH)
  ) u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mm_start),
    .a_i      (mm_a),
    .b_i      (mm_b),
    .mod_i    (modulus_q),
    .status_o (mm_status),
    .product_o(mm_product)
  );

  // sequencer: reduce the value, then square (and multiply) per exponent bit
  always_comb begin
    state_d  = state_q;
    exp_d    = exp_q;
    base_d   = base_q;
    acc_d    = acc_q;
    bit_d    = bit_q;
    err_d    = err_q;
    mm_start = 1'b0;
    mm_a     = mm_product;
    mm_b     = mm_product;
    out_load = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          exp_d = s_axis_tuser_i ? priv_exp_q : pub_exp_q;
          bit_d = CNT_W'(KEY_WIDTH - 1);
          err_d = 1'b0;
          if (!s_axis_tuser_i && (value_ext > modulus_q)) begin
            err_d   = 1'b1;
            acc_d   = '0;
            state_d = ST_FINISH;
          end else if (modulus_q == '0) begin
            acc_d   = '0;
            state_d = ST_FINISH;
          end else begin
            // value mod n computed as (1 * value) mod n
            mm_start = 1'b1;
            mm_a     = one_mod;
            mm_b     = value_ext;
            state_d  = ST_REDUCE;
          end
        end
      end

      ST_REDUCE: begin
        if (mm_status.done) begin
          base_d   = mm_product;
          acc_d    = one_mod;
          mm_start = 1'b1;
          mm_a     = one_mod;
          mm_b     = one_mod;
          state_d  = ST_SQUARE;
        end
      end

      ST_SQUARE, ST_MULT: begin
        if (mm_status.done) begin
          acc_d = mm_product;
          if ((state_q == ST_SQUARE) && exp_q[KEY_WIDTH-1]) begin
            mm_start = 1'b1;
            mm_b     = base_q;
            state_d  = ST_MULT;
          end else if (bit_q == '0) begin
            state_d = ST_FINISH;
          end else begin
            // advance to the next exponent bit
            bit_d    = bit_q - CNT_W'(1);
            exp_d    = {exp_q[KEY_WIDTH-2:0], 1'b0};
            mm_start = 1'b1;
            state_d  = ST_SQUARE;
          end
        end
      end

      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      err_q       <= 1'b0;
      bit_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      err_q       <= err_d;
      bit_q       <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q  <= exp_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    if (out_load) begin
      out_data_q <= DATA_W'(acc_q);
      out_err_q  <= err_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_err_q;

  // the multiplier is never started while it still works on a product
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_start |-> !mm_status.busy)
    else $error("multiplier restarted while busy");

  // an idle sequencer leaves the multiplier idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !mm_status.busy)
    else $error("multiplier busy while unit is idle");

  // every finished product is reduced below the modulus
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_status.done |-> (mm_product < modulus_q))
    else $error("product not reduced");

  // an error item carries a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("error item with nonzero result");

endmodule : rsa_modular_exponentiation_unit

`default_nettype wire

// ===== bench/rsa_modexp_checker.sv =====
// Result checker for the RSA modular exponentiation unit: tracks the key
// registers, predicts each result item and compares it. Uses rsa_me_pkg.
`timescale 1ns / 100ps

module rsa_modexp_checker
  import rsa_me_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  input  logic [DATA_W-1:0]    s_axis_tdata_i,   // [31:0] value
  input  logic                 s_axis_tuser_i,   // [0] mode
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  input  logic [DATA_W-1:0]    m_axis_tdata_i,   // [31:0] result
  input  logic                 m_axis_tuser_i,   // [0] error
  output int unsigned          pending_o,
  output int unsigned          errors_o
);

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              error;
  } modexp_out_t;

  logic [DATA_W-1:0] modulus_q;
  logic [DATA_W-1:0] pub_exp_q;
  logic [DATA_W-1:0] priv_exp_q;
  modexp_out_t       expected_results[$];
  int unsigned       mismatch_count;

  // a * b mod n for a, b < n, n nonzero
  function automatic logic [DATA_W-1:0] mul_reduce(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b,
                                                   input logic [DATA_W-1:0] n);
    logic [2*DATA_W-1:0] prod;
    prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    prod = prod % {{DATA_W{1'b0}}, n};
    return prod[DATA_W-1:0];
  endfunction

  // Left-to-right square and multiply; a zero modulus yields zero
  function automatic logic [DATA_W-1:0] pow_reduce(input logic [DATA_W-1:0] base,
                                                   input logic [DATA_W-1:0] expo,
                                                   input logic [DATA_W-1:0] n);
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] b;
    int                i;
    if (n == '0) return '0;
    acc = (n == DATA_W'(1)) ? '0 : DATA_W'(1);
    b   = base % n;
    for (i = DATA_W - 1; i >= 0; i--) begin
      acc = mul_reduce(acc, acc, n);
      if (expo[i]) acc = mul_reduce(acc, b, n);
    end
    return acc;
  endfunction

  // Public mode rejects values strictly above the modulus
  function automatic modexp_out_t predict_modexp(input logic              use_private,
                                                 input logic [DATA_W-1:0] value);
    modexp_out_t r;
    if (!use_private && value > modulus_q) begin
      r.result = '0;
      r.error  = 1'b1;
    end else begin
      r.result = pow_reduce(value, use_private ? priv_exp_q : pub_exp_q, modulus_q);
      r.error  = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    modexp_out_t want;
    if (!rst_ni) begin
      modulus_q  = DATA_W'(2);
      pub_exp_q  = DATA_W'(1);
      priv_exp_q = DATA_W'(1);
      expected_results.delete();
      mismatch_count = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          REG_MODULUS:     modulus_q  = cfg_data_i;
          REG_PUBLIC_EXP:  pub_exp_q  = cfg_data_i;
          REG_PRIVATE_EXP: priv_exp_q = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result item: expected none, got result %h error %b",
                   $time, m_axis_tdata_i, m_axis_tuser_i);
        end else begin
          want = expected_results.pop_front();
          if (want.result !== m_axis_tdata_i) begin
            mismatch_count++;
            $display("%0t: result mismatch: expected %h, got %h",
                     $time, want.result, m_axis_tdata_i);
          end
          if (want.error !== m_axis_tuser_i) begin
            mismatch_count++;
            $display("%0t: error flag mismatch: expected %b, got %b",
                     $time, want.error, m_axis_tuser_i);
          end
        end
      end
      // append the prediction at the tail of the queue
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_results = {expected_results,
                            predict_modexp(s_axis_tuser_i, s_axis_tdata_i)};
      pending_o <= expected_results.size();
      errors_o  <= mismatch_count;
    end
  end

endmodule

// ===== bench/tb.sv =====
// Top of the RSA modular exponentiation bench: clock, reset, key writes,
// input items and receiver stalls. Depends on rsa_me_pkg and rsa_modexp_checker.
`timescale 1ns / 100ps

module tb
  import rsa_me_pkg::*;
;

  localparam int unsigned CLK_PERIOD = 10;
  // Limit on the whole run, with a wide margin over the slowest items
  localparam int unsigned TIMEOUT_CYCLES  = 3_000_000;
  localparam int unsigned RANDOM_PHASES   = 12;
  localparam int unsigned ITEMS_PER_PHASE = 22;
  // Quiet period after the last result; the slowest item is far longer
  localparam int unsigned TAIL_CYCLES = 64;

  // Mode bit carried in s_axis_tuser
  localparam logic MODE_PUBLIC  = 1'b0;
  localparam logic MODE_PRIVATE = 1'b1;
  // Index with no register behind it; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // Idle profiles
  localparam int unsigned IDLE_NONE     = 0;
  localparam int unsigned IDLE_SENDER   = 1;
  localparam int unsigned IDLE_RECEIVER = 2;
  localparam int unsigned IDLE_BOTH     = 3;

  logic                 clk_i    = 1'b0;
  logic                 rst_ni   = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [DATA_W-1:0]    s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [DATA_W-1:0]    m_tdata;
  logic                 m_tuser;

  int unsigned pending;
  int unsigned errors;
  int unsigned cycle_count  = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  // Modulus currently loaded, used only to shape the random values
  logic [DATA_W-1:0] cur_modulus = DATA_W'(2);
  logic [DATA_W-1:0] rand_modulus;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  rsa_modular_exponentiation_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  rsa_modexp_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .pending_o       (pending),
    .errors_o        (errors)
  );

  // Receiver: drop tready at random according to the current stall rate
  always @(posedge clk_i) m_tready <= ($urandom_range(99) >= rx_stall_pct);

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Pick sender and receiver idle rates for the next stretch of items
  task automatic set_idle(input int unsigned profile);
    case (profile)
      IDLE_SENDER:   begin tx_idle_pct = 84; rx_stall_pct = 0;  end
      IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 84; end
      IDLE_BOTH:     begin tx_idle_pct = 20; rx_stall_pct = 20; end
      default:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
    endcase
  endtask

  // Offer one item, after an optional random gap, and hold it until taken.
  // tvalid is left high so back-to-back items need no extra edge.
  task automatic send_item(input logic mode, input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= mode;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Drop tvalid and wait until every accepted item has its result back.
  // The first edge lets the checker count an item taken on this very edge.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Hold one register write until the unit takes it; cfg_valid stays high
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Load a new key while the unit is idle; a stray write to the unmapped
  // index goes first and must leave the key untouched
  task automatic apply_key(input logic [DATA_W-1:0] n, input logic [DATA_W-1:0] e,
                           input logic [DATA_W-1:0] d);
    drain_results();
    write_reg(REG_UNMAPPED, $urandom);
    write_reg(REG_MODULUS, n);
    write_reg(REG_PUBLIC_EXP, e);
    write_reg(REG_PRIVATE_EXP, d);
    cfg_valid   <= 1'b0;
    cur_modulus = n;
  endtask

  // Mostly values below the modulus, so the full exponentiation runs;
  // the rest probe the range check edge, tiny values and the whole word
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return (cur_modulus == '0) ? '0 : DATA_W'($urandom) % cur_modulus;
    else if (r < 72) return cur_modulus;
    else if (r < 78) return cur_modulus + DATA_W'(1);
    else if (r < 85) return DATA_W'($urandom_range(3));
    else return DATA_W'($urandom);
  endfunction

  function automatic logic [DATA_W-1:0] pick_exponent();
    case ($urandom_range(3))
      0:       return DATA_W'($urandom_range(65537));
      1:       return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    // Hold reset, then release it on an edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset key: n = 2, e = d = 1
    set_idle(IDLE_NONE);
    send_item(MODE_PUBLIC, DATA_W'(0));
    send_item(MODE_PUBLIC, DATA_W'(2));   // equal to the modulus: no error
    send_item(MODE_PUBLIC, DATA_W'(3));   // above the modulus: error
    send_item(MODE_PRIVATE, DATA_W'(3));  // reduced before exponentiation
    send_item(MODE_PRIVATE, '1);

    // All-ones modulus and exponents
    apply_key('1, '1, '1);
    set_idle(IDLE_RECEIVER);
    send_item(MODE_PUBLIC, '1);
    send_item(MODE_PUBLIC, ~DATA_W'(1));
    send_item(MODE_PRIVATE, '1);
    send_item(MODE_PRIVATE, DATA_W'(0));

    // Modulus of one with zero exponents: every result is zero
    apply_key(DATA_W'(1), '0, '0);
    set_idle(IDLE_SENDER);
    send_item(MODE_PUBLIC, DATA_W'(1));
    send_item(MODE_PUBLIC, DATA_W'(0));
    send_item(MODE_PUBLIC, DATA_W'(2));
    send_item(MODE_PRIVATE, '1);

    // Zero modulus: zero result, any nonzero public value is an error
    apply_key('0, DATA_W'(5), DATA_W'(7));
    set_idle(IDLE_BOTH);
    send_item(MODE_PUBLIC, DATA_W'(0));
    send_item(MODE_PUBLIC, DATA_W'(1));
    send_item(MODE_PRIVATE, DATA_W'(12345));

    // Small textbook key: encrypt 65, decrypt its ciphertext
    apply_key(DATA_W'(3233), DATA_W'(17), DATA_W'(2753));
    set_idle(IDLE_NONE);
    send_item(MODE_PUBLIC, DATA_W'(65));
    send_item(MODE_PRIVATE, DATA_W'(2790));
    send_item(MODE_PUBLIC, DATA_W'(3234));
    send_item(MODE_PUBLIC, DATA_W'(3233));

    // Large prime modulus, zero public exponent
    apply_key(32'hFFFF_FFFB, '0, DATA_W'(65537));
    send_item(MODE_PUBLIC, DATA_W'(5));
    send_item(MODE_PRIVATE, '1);

    // Random keys, cycling through the idle profiles
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(3))
        0:       rand_modulus = DATA_W'($urandom_range(1000, 2));
        1:       rand_modulus = DATA_W'($urandom_range(65535, 2));
        2:       rand_modulus = DATA_W'($urandom) | 32'h8000_0000;
        default: rand_modulus = DATA_W'($urandom);
      endcase
      apply_key(rand_modulus, pick_exponent(), pick_exponent());
      set_idle(p % 4);
      repeat (ITEMS_PER_PHASE) send_item(1'($urandom_range(1)), pick_value());
    end

    // Wait for the last results, then watch for strays
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    while (cycle_count < TIMEOUT_CYCLES) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
